@@ rtl/dsw_pkg.sv @@
package dsw_pkg;

  // sizes of the table and of the item fields
  localparam int unsigned MAX_DICE     = 32;
  localparam int unsigned MAX_FACES    = 64;
  localparam int unsigned TARGET_DEPTH = 1024;

  localparam int unsigned DICE_W  = 6;
  localparam int unsigned FACES_W = 7;
  localparam int unsigned TGT_W   = $clog2(TARGET_DEPTH);
  localparam int unsigned CNT_W   = 31;
  localparam int unsigned ADDR_W  = TGT_W + 1;

  localparam logic [CNT_W-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_TURN,
    ST_FETCH,
    ST_RESULT
  } seq_state_e;

  // control that travels with one read pair into the window update
  typedef struct packed {
    logic valid;
    logic first;
    logic virt;
    logic a_use;
    logic b_use;
    logic a_one;
    logic b_one;
  } win_ctl_t;

  // result request from the sequencer
  typedef struct packed {
    logic valid;
    logic direct;
    logic direct_val;
  } res_req_t;

endpackage

@@ rtl/dsw_ram.sv @@
module dsw_ram #(
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 31
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/dsw_window.sv @@
module dsw_window (
  input  logic                      clk_i,
  input  dsw_pkg::win_ctl_t         ctl_i,
  input  logic [dsw_pkg::CNT_W-1:0] rdata_a_i,
  input  logic [dsw_pkg::CNT_W-1:0] rdata_b_i,
  input  logic [dsw_pkg::CNT_W-1:0] mod_i,
  input  logic                      one_i,
  output logic [dsw_pkg::CNT_W-1:0] sum_o
);

  logic [dsw_pkg::CNT_W-1:0] acc_q;
  logic [dsw_pkg::CNT_W-1:0] base;
  logic [dsw_pkg::CNT_W-1:0] add_v;
  logic [dsw_pkg::CNT_W-1:0] sub_v;
  logic [dsw_pkg::CNT_W+1:0] s0;
  logic [dsw_pkg::CNT_W+1:0] s_lo;
  logic [dsw_pkg::CNT_W+1:0] s_hi;

  // running sum (zero on the first column) plus entering value minus leaving value, folded back into [0, m)
  always_comb begin
    base = ctl_i.first ? '0 : acc_q;
    if (!ctl_i.a_use) begin
      add_v = '0;
    end else if (ctl_i.virt) begin
      add_v = {{(dsw_pkg::CNT_W-1){1'b0}}, ctl_i.a_one & one_i};
    end else begin
      add_v = rdata_a_i;
    end
    if (!ctl_i.b_use) begin
      sub_v = '0;
    end else if (ctl_i.virt) begin
      sub_v = {{(dsw_pkg::CNT_W-1){1'b0}}, ctl_i.b_one & one_i};
    end else begin
      sub_v = rdata_b_i;
    end
    s0   = {2'b00, base} + {2'b00, add_v} - {2'b00, sub_v};
    s_lo = s0 + {2'b00, mod_i};
    s_hi = s0 - {2'b00, mod_i};
    if (s0[dsw_pkg::CNT_W+1]) begin
      sum_o = s_lo[dsw_pkg::CNT_W-1:0];
    end else if (!s_hi[dsw_pkg::CNT_W+1]) begin
      sum_o = s_hi[dsw_pkg::CNT_W-1:0];
    end else begin
      sum_o = s0[dsw_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      acc_q <= sum_o;
    end
  end

endmodule

@@ rtl/dsw_seq.sv @@
module dsw_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [dsw_pkg::DICE_W-1:0]  num_dice_i,
  input  logic [dsw_pkg::FACES_W-1:0] faces_i,
  input  logic [dsw_pkg::TGT_W-1:0]   target_sum_i,
  input  logic [dsw_pkg::CNT_W-1:0]   modulus_i,
  output logic                        busy,
  output logic [dsw_pkg::ADDR_W-1:0]  raddr_a_o,
  output logic [dsw_pkg::ADDR_W-1:0]  raddr_b_o,
  output logic [dsw_pkg::ADDR_W-1:0]  waddr_o,
  output dsw_pkg::win_ctl_t           ctl_o,
  output logic [dsw_pkg::CNT_W-1:0]   mod_o,
  output logic                        one_o,
  output dsw_pkg::res_req_t           res_o
);

  dsw_pkg::seq_state_e state_q, state_d;
  logic [dsw_pkg::DICE_W-1:0]  nd_q, nd_d;
  logic [dsw_pkg::FACES_W-1:0] nf_q, nf_d;
  logic [dsw_pkg::TGT_W-1:0]   tg_q, tg_d;
  logic [dsw_pkg::CNT_W-1:0]   m_q, m_d;
  logic                        one_q, one_d;
  logic [dsw_pkg::DICE_W-1:0]  d_q, d_d;
  logic [dsw_pkg::TGT_W-1:0]   t_q, t_d;
  dsw_pkg::win_ctl_t           ctl_q, ctl_d;
  logic [dsw_pkg::ADDR_W-1:0]  waddr_q, waddr_d;
  dsw_pkg::res_req_t           res_q, res_d;
  logic [dsw_pkg::DICE_W-1:0]  nd_sat;
  logic [dsw_pkg::FACES_W-1:0] nf_sat;
  logic [dsw_pkg::TGT_W:0]     t_ext;
  logic [dsw_pkg::TGT_W:0]     nf_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsw_pkg::ST_IDLE;
      ctl_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      ctl_q   <= ctl_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q    <= nd_d;
    nf_q    <= nf_d;
    tg_q    <= tg_d;
    m_q     <= m_d;
    one_q   <= one_d;
    d_q     <= d_d;
    t_q     <= t_d;
    waddr_q <= waddr_d;
  end

  always_comb begin
    nd_sat = (num_dice_i > dsw_pkg::DICE_W'(dsw_pkg::MAX_DICE)) ?
             dsw_pkg::DICE_W'(dsw_pkg::MAX_DICE) : num_dice_i;
    nf_sat = (faces_i > dsw_pkg::FACES_W'(dsw_pkg::MAX_FACES)) ?
             dsw_pkg::FACES_W'(dsw_pkg::MAX_FACES) : faces_i;
    t_ext  = {1'b0, t_q};
    nf_ext = (dsw_pkg::TGT_W+1)'(nf_q);

    state_d = state_q;
    nd_d    = nd_q;
    nf_d    = nf_q;
    tg_d    = tg_q;
    m_d     = m_q;
    one_d   = one_q;
    d_d     = d_q;
    t_d     = t_q;
    waddr_d = waddr_q;
    ctl_d   = '0;
    res_d   = '0;

    // reads look one and faces+1 places back in the previous row
    raddr_a_o = {~d_q[0], t_q - dsw_pkg::TGT_W'(1)};
    raddr_b_o = {~d_q[0], t_q - dsw_pkg::TGT_W'(1) - dsw_pkg::TGT_W'(nf_q)};

    case (state_q)
      dsw_pkg::ST_IDLE: begin
        if (start) begin
          nd_d  = nd_sat;
          nf_d  = nf_sat;
          tg_d  = target_sum_i;
          m_d   = (modulus_i < dsw_pkg::CNT_W'(2)) ? dsw_pkg::CNT_W'(1) : modulus_i;
          one_d = (modulus_i >= dsw_pkg::CNT_W'(2));
          if (nd_sat == '0) begin
            res_d.valid      = 1'b1;
            res_d.direct     = 1'b1;
            res_d.direct_val = (target_sum_i == '0) &&
                               (modulus_i >= dsw_pkg::CNT_W'(2));
          end else begin
            d_d     = dsw_pkg::DICE_W'(1);
            t_d     = '0;
            state_d = dsw_pkg::ST_ROW;
          end
        end
      end
      dsw_pkg::ST_ROW: begin
        ctl_d.valid = 1'b1;
        ctl_d.first = (t_q == '0);
        ctl_d.virt  = (d_q == dsw_pkg::DICE_W'(1));
        ctl_d.a_use = (t_q != '0);
        ctl_d.b_use = (t_ext > nf_ext);
        ctl_d.a_one = (t_q == dsw_pkg::TGT_W'(1));
        ctl_d.b_one = (t_ext == nf_ext + (dsw_pkg::TGT_W+1)'(1));
        waddr_d     = {d_q[0], t_q};
        if (t_q == tg_q) begin
          state_d = dsw_pkg::ST_TURN;
        end else begin
          t_d = t_q + dsw_pkg::TGT_W'(1);
        end
      end
      dsw_pkg::ST_TURN: begin
        // last write of the row lands here before the next row reads it
        if (d_q == nd_q) begin
          state_d = dsw_pkg::ST_FETCH;
        end else begin
          d_d     = d_q + dsw_pkg::DICE_W'(1);
          t_d     = '0;
          state_d = dsw_pkg::ST_ROW;
        end
      end
      dsw_pkg::ST_FETCH: begin
        raddr_a_o = {nd_q[0], tg_q};
        state_d   = dsw_pkg::ST_RESULT;
      end
      dsw_pkg::ST_RESULT: begin
        // keep the final entry on the read port for the result register
        raddr_a_o   = {nd_q[0], tg_q};
        res_d.valid = 1'b1;
        state_d     = dsw_pkg::ST_IDLE;
      end
      default: begin
        state_d = dsw_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy    = (state_q != dsw_pkg::ST_IDLE);
  assign waddr_o = waddr_q;
  assign ctl_o   = ctl_q;
  assign mod_o   = m_q;
  assign one_o   = one_q;
  assign res_o   = res_q;

  a_ctl_from_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid |-> $past(state_q) == dsw_pkg::ST_ROW)
    else $error("window update without a row read");

  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsw_pkg::ST_ROW |-> t_q <= tg_q)
    else $error("column beyond target");

  a_d_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsw_pkg::ST_ROW |-> (d_q != '0) && (d_q <= nd_q))
    else $error("row index out of range");

  a_b_after_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.b_use |-> ctl_q.a_use)
    else $error("leaving entry without entering entry");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> state_q == dsw_pkg::ST_IDLE)
    else $error("result while still busy");

endmodule

@@ rtl/dice_sum_way_counter_core.sv @@
// result: for zero dice the answer passes the sequencer's result request register and then
//   the result register; otherwise it follows the row sweep (saturated dice count) and the fetch and result states
// throughput: one item at a time; busy holds through the row sweep of one entry per
//   cycle (never for zero dice)
// reset: async active low, returns to idle, modulus back to 1000000007
// the result strobe lasts one cycle and the receiver cannot stall it
module dice_sum_way_counter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        start,
  output logic                        busy,
  input  logic [dsw_pkg::DICE_W-1:0]  num_dice_i,
  input  logic [dsw_pkg::FACES_W-1:0] faces_i,
  input  logic [dsw_pkg::TGT_W-1:0]   target_sum_i,
  // result channel
  output logic                        way_valid_o,
  output logic [dsw_pkg::CNT_W-1:0]   way_count_o,
  // modulus write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dsw_pkg::CNT_W-1:0]   cfg_data_i
);

  logic [dsw_pkg::CNT_W-1:0]  mod_q;
  logic [dsw_pkg::ADDR_W-1:0] raddr_a;
  logic [dsw_pkg::ADDR_W-1:0] raddr_b;
  logic [dsw_pkg::ADDR_W-1:0] waddr;
  logic [dsw_pkg::CNT_W-1:0]  rdata_a;
  logic [dsw_pkg::CNT_W-1:0]  rdata_b;
  logic [dsw_pkg::CNT_W-1:0]  sum;
  logic [dsw_pkg::CNT_W-1:0]  m_eff;
  logic                       one;
  dsw_pkg::win_ctl_t          ctl;
  dsw_pkg::res_req_t          res;
  logic                       way_valid_q;
  logic [dsw_pkg::CNT_W-1:0]  way_count_q, way_count_d;

  // modulus register, always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= dsw_pkg::MOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_data_i;
    end
  end

  // sequencer: walks rows (one per die) and columns (0..target)
  dsw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .num_dice_i   (num_dice_i),
    .faces_i      (faces_i),
    .target_sum_i (target_sum_i),
    .modulus_i    (mod_q),
    .busy         (busy),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .waddr_o      (waddr),
    .ctl_o        (ctl),
    .mod_o        (m_eff),
    .one_o        (one),
    .res_o        (res)
  );

  // two rows of counts, used alternately; bank = row parity
  dsw_ram #(
    .ADDR_W (dsw_pkg::ADDR_W),
    .DATA_W (dsw_pkg::CNT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctl.valid),
    .waddr_i   (waddr),
    .wdata_i   (sum),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // sliding window sum: add the entering entry, drop the one leaving
  dsw_window u_window (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .mod_i     (m_eff),
    .one_i     (one),
    .sum_o     (sum)
  );

  // result register: zero dice answer directly, else the final table read
  always_comb begin
    if (res.direct) begin
      way_count_d = {{(dsw_pkg::CNT_W-1){1'b0}}, res.direct_val};
    end else begin
      way_count_d = rdata_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_valid_q <= 1'b0;
    end else begin
      way_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      way_count_q <= way_count_d;
    end
  end

  assign way_valid_o = way_valid_q;
  assign way_count_o = way_count_q;

endmodule

@@ test/dice_sum_way_counter_core_tb.sv @@
module dice_sum_way_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsw_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 200_000;

  typedef struct packed {
    logic [DICE_W-1:0]  dice;
    logic [FACES_W-1:0] faces;
    logic [TGT_W-1:0]   target;
  } roll_req_t;

  // one outstanding answer: the request that caused it and its way count
  typedef struct {
    roll_req_t        req;
    logic [CNT_W-1:0] ways;
  } way_due_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [DICE_W-1:0]  num_dice_i = '0;
  logic [FACES_W-1:0] faces_i = '0;
  logic [TGT_W-1:0]   target_sum_i = '0;
  logic               way_valid_o;
  logic [CNT_W-1:0]   way_count_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CNT_W-1:0]   cfg_data_i = '0;

  roll_req_t        pending_rolls[$];
  way_due_t         ways_due[$];
  logic [CNT_W-1:0] modulus_shadow = MOD_RESET;
  int unsigned      sender_idle_pct = 0;
  int unsigned      mismatch_cnt = 0;

  dice_sum_way_counter_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .num_dice_i   (num_dice_i),
    .faces_i      (faces_i),
    .target_sum_i (target_sum_i),
    .way_valid_o  (way_valid_o),
    .way_count_o  (way_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // number of ordered rolls reaching the target, modulo the modulus
  // two rows of partial counts, one new row per die
  function automatic logic [CNT_W-1:0] count_ways(roll_req_t req, logic [CNT_W-1:0] modv);
    longint unsigned prev_row [TARGET_DEPTH];
    longint unsigned next_row [TARGET_DEPTH];
    longint unsigned m;
    longint unsigned acc;
    int nd;
    int nf;
    int tg;
    // a modulus of 0 or 1 behaves as 1, so everything collapses to zero
    m  = (modv < CNT_W'(2)) ? 64'd1 : 64'(modv);
    // dice and faces beyond the table size saturate
    nd = (req.dice > MAX_DICE) ? int'(MAX_DICE) : int'(req.dice);
    nf = (req.faces > MAX_FACES) ? int'(MAX_FACES) : int'(req.faces);
    tg = int'(req.target);
    for (int t = 0; t <= tg; t++) prev_row[t] = (t == 0) ? (64'd1 % m) : 64'd0;
    for (int d = 1; d <= nd; d++) begin
      for (int t = 0; t <= tg; t++) begin
        // window of up to nf entries behind t in the previous row
        acc = 64'd0;
        for (int i = 1; i <= nf && i <= t; i++) acc += prev_row[t-i];
        next_row[t] = acc % m;
      end
      for (int t = 0; t <= tg; t++) prev_row[t] = next_row[t];
    end
    return CNT_W'(prev_row[tg]);
  endfunction

  // mostly cheap requests; wide fields appear with short sweeps,
  // long targets with few dice, and only rarely a full-size sweep
  function automatic roll_req_t rand_roll();
    roll_req_t   r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.dice   = DICE_W'($urandom_range(8));
      r.faces  = FACES_W'($urandom_range(16));
      r.target = TGT_W'($urandom_range(64));
    end else if (pick < 90) begin
      r.dice   = DICE_W'($urandom_range(63));
      r.faces  = FACES_W'($urandom_range(127));
      r.target = TGT_W'($urandom_range(127));
    end else if (pick < 98) begin
      r.dice   = DICE_W'($urandom_range(10));
      r.faces  = FACES_W'($urandom_range(127));
      r.target = TGT_W'($urandom_range(1023));
    end else begin
      r.dice   = DICE_W'($urandom_range(63));
      r.faces  = FACES_W'($urandom_range(127));
      r.target = TGT_W'($urandom_range(1023));
    end
    return r;
  endfunction

  task automatic queue_roll(int unsigned d, int unsigned f, int unsigned t);
    roll_req_t r;
    r.dice   = DICE_W'(d);
    r.faces  = FACES_W'(f);
    r.target = TGT_W'(t);
    pending_rolls.push_back(r);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_rolls.push_back(rand_roll());
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // modulus writes happen only with the block idle
  task automatic write_modulus(logic [CNT_W-1:0] modv);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= modv;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_shadow = modv;
    @(negedge clk_i);
  endtask

  // all items sent, all answers back, block no longer busy
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_rolls.size() != 0 || start || ways_due.size() != 0 || busy)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // request driver: holds start until accepted, then pulls the next item
  always @(posedge clk_i or negedge rst_ni) begin : drive_rolls
    roll_req_t cur;
    roll_req_t nxt;
    way_due_t  due;
    logic      launch;
    if (!rst_ni) begin
      start        <= 1'b0;
      num_dice_i   <= '0;
      faces_i      <= '0;
      target_sum_i <= '0;
    end else begin
      // still waiting on busy: keep the item on the ports
      launch = start && busy;
      if (start && !busy) begin
        cur.dice   = num_dice_i;
        cur.faces  = faces_i;
        cur.target = target_sum_i;
        due.req    = cur;
        due.ways   = count_ways(cur, modulus_shadow);
        ways_due.push_back(due);
      end
      // random sender gaps between items
      if (!launch && pending_rolls.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_rolls.pop_front();
        num_dice_i   <= nxt.dice;
        faces_i      <= nxt.faces;
        target_sum_i <= nxt.target;
        launch = 1'b1;
      end
      // a single assignment to start per edge
      start <= launch;
    end
  end

  // result checker: every strobe must match the oldest outstanding answer
  always @(posedge clk_i) begin : check_ways
    way_due_t due;
    if (rst_ni && way_valid_o) begin
      if (ways_due.size() == 0) begin
        report_mismatch($sformatf("way_count %0d with no item outstanding", way_count_o));
      end else begin
        due = ways_due.pop_front();
        if (way_count_o !== due.ways)
          report_mismatch($sformatf("dice %0d faces %0d target %0d: way_count %0d, expected %0d",
                                    due.req.dice, due.req.faces, due.req.target,
                                    way_count_o, due.ways));
      end
    end
  end

  // hang detection: any accepted handshake restarts the count
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (start && !busy) || way_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR @%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
        $display("dice_sum_way_counter_core_tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pass with the reset modulus
    sender_idle_pct = 23;
    // zero dice: only a zero target counts
    queue_roll(0, 0, 0);
    queue_roll(0, 5, 3);
    queue_roll(0, 127, 1023);
    // small hand-checkable counts
    queue_roll(1, 6, 3);
    queue_roll(2, 6, 7);
    queue_roll(3, 6, 10);
    queue_roll(1, 1, 1);
    queue_roll(2, 1, 2);
    queue_roll(10, 10, 55);
    queue_roll(30, 6, 100);
    // dice present but target zero
    queue_roll(5, 6, 0);
    // zero faces
    queue_roll(3, 0, 5);
    queue_roll(1, 0, 0);
    // dice count saturates at the table size
    queue_roll(63, 1, 32);
    queue_roll(40, 1, 32);
    queue_roll(33, 2, 40);
    // face count saturates at the table size
    queue_roll(1, 127, 64);
    queue_roll(1, 127, 65);
    queue_roll(1, 100, 64);
    // long sweeps, the last with all field bits high
    queue_roll(20, 64, 512);
    queue_roll(32, 64, 1023);
    queue_roll(63, 127, 1023);
    wait_drained();

    // largest modulus
    write_modulus(31'h7FFF_FFFF);
    queue_random(15);
    wait_drained();

    // smallest legal modulus
    write_modulus(31'd2);
    queue_random(15);
    wait_drained();

    // degenerate moduli: every count is zero
    sender_idle_pct = 75;
    write_modulus(31'd0);
    queue_roll(0, 0, 0);
    queue_roll(3, 6, 10);
    queue_random(4);
    wait_drained();

    write_modulus(31'd1);
    queue_roll(0, 0, 0);
    queue_roll(3, 6, 10);
    queue_random(4);
    wait_drained();

    write_modulus(CNT_W'($urandom));
    queue_random(15);
    wait_drained();

    // back to the usual modulus, back-to-back items
    sender_idle_pct = 0;
    write_modulus(MOD_RESET);
    queue_random(15);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("dice_sum_way_counter_core_tb passed");
    else
      $display("dice_sum_way_counter_core_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dsw_pkg.sv
rtl/dsw_ram.sv
rtl/dsw_window.sv
rtl/dsw_seq.sv
rtl/dice_sum_way_counter_core.sv
test/dice_sum_way_counter_core_tb.sv
